// ----- rtl/core/lcd_seq_pkg.sv -----
// Shared types, codes and tables for the character LCD 4-bit write sequencer.
// Used by the front, queue, back and top-level modules. No dependencies.
`timescale 1ns / 1ps

package lcd_seq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // command codes on the request channel
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_INSTR  = 3'd1;
   localparam logic [2:0] CMD_CHAR   = 3'd2;
   localparam logic [2:0] CMD_RAW    = 3'd3;
   localparam logic [2:0] CMD_CURSOR = 3'd4;

   // cursor row codes and their line bases
   localparam logic [2:0] ROW_LINE1 = 3'd1;
   localparam logic [2:0] ROW_LINE2 = 3'd2;
   localparam logic [2:0] ROW_LINE3 = 3'd3;
   localparam logic [2:0] ROW_LINE4 = 3'd4;
   localparam logic [7:0] BASE_LINE1 = 8'h80;
   localparam logic [7:0] BASE_LINE2 = 8'hC0;
   localparam logic [7:0] BASE_LINE3 = 8'h93;
   localparam logic [7:0] BASE_LINE4 = 8'hD3;

   localparam logic [7:0] INIT_FINAL_BYTE = 8'h0C;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CODE_SPACE      = 8'h80;
   localparam logic [7:0] CODE_UNKNOWN    = 8'h01;

   // step numbering: init setup pulses first, then the eight byte-write segments
   localparam int         INIT_SEGS  = 35;
   localparam logic [5:0] BYTE_START = 6'd35;
   localparam logic [5:0] STEP_FINAL = 6'd42;

   localparam logic       INIT_EN   [0:INIT_SEGS-1] = '{
      1'b0,
      1'b1, 1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b0, 1'b0,  1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0, 1'b0
   };
   localparam logic [3:0] INIT_NIB  [0:INIT_SEGS-1] = '{
      4'h0,
      4'h0, 4'h2, 4'h2, 4'h0,  4'h0, 4'h2, 4'h2, 4'h0,  4'h0, 4'h8, 4'h8, 4'h0,
      4'h0, 4'h0, 4'h0,
      4'h0, 4'hE, 4'hE, 4'h0,  4'h0, 4'h0, 4'h0,  4'h0, 4'h6, 4'h6, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0,  4'h0, 4'h1, 4'h1, 4'h0
   };
   localparam logic [4:0] INIT_HOLD [0:INIT_SEGS-1] = '{
      5'd30,
      5'd1, 5'd2, 5'd1, 5'd3,  5'd1, 5'd2, 5'd1, 5'd2,  5'd1, 5'd2, 5'd1, 5'd3,
      5'd3, 5'd1, 5'd2,
      5'd1, 5'd2, 5'd1, 5'd3,  5'd3, 5'd1, 5'd2,  5'd1, 5'd2, 5'd1, 5'd3,
      5'd1, 5'd2, 5'd1, 5'd2,  5'd1, 5'd2, 5'd1, 5'd10
   };

   // one classified command waiting for the back end
   typedef struct packed {
      logic       is_init;
      logic       is_data;
      logic [7:0] value;
   } cmd_entry_type;

   // one pin segment
   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [3:0] data_nibble;
      logic [4:0] hold_ms;
      logic       last;
   } seg_type;

endpackage

// ----- rtl/core/lcd_seq_front.sv -----
// Front end: accepts request items, maps characters and cursor addresses,
// and pushes one classified entry per valid command. Depends on lcd_seq_pkg.
`timescale 1ns / 1ps

module lcd_seq_front
   import lcd_seq_pkg::*;
(
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    command,
   input  logic [7:0]    byte_value,
   input  logic [2:0]    row,
   input  logic [7:0]    column,
   input  logic          q_full,
   output logic          q_push,
   output cmd_entry_type q_entry
);

   logic       known_char;
   logic [7:0] mapped;
   logic [7:0] base;
   logic       cmd_known;

   always_comb begin
      known_char = ((byte_value >= 8'h41) && (byte_value <= 8'h5A)) ||
                   ((byte_value >= 8'h61) && (byte_value <= 8'h7A)) ||
                   ((byte_value >= 8'h30) && (byte_value <= 8'h39)) ||
                   (byte_value == 8'h21) ||
                   ((byte_value >= 8'h23) && (byte_value <= 8'h26)) ||
                   ((byte_value >= 8'h28) && (byte_value <= 8'h2B)) ||
                   ((byte_value >= 8'h2D) && (byte_value <= 8'h2F)) ||
                   ((byte_value >= 8'h3A) && (byte_value <= 8'h40)) ||
                   (byte_value == 8'h5B) ||
                   ((byte_value >= 8'h5D) && (byte_value <= 8'h60)) ||
                   ((byte_value >= 8'h7B) && (byte_value <= 8'h7D));
      if (byte_value == CHAR_SPACE) begin
         mapped = CODE_SPACE;
      end else if (known_char) begin
         mapped = byte_value;
      end else begin
         mapped = CODE_UNKNOWN;
      end
   end

   always_comb begin
      case (row)
         ROW_LINE1: base = BASE_LINE1;
         ROW_LINE2: base = BASE_LINE2;
         ROW_LINE3: base = BASE_LINE3;
         ROW_LINE4: base = BASE_LINE4;
         default:   base = 8'h00;
      endcase
   end

   always_comb begin
      cmd_known        = 1'b1;
      q_entry.is_init  = 1'b0;
      q_entry.is_data  = 1'b0;
      q_entry.value    = byte_value;
      case (command)
         CMD_INIT: begin
            q_entry.is_init = 1'b1;
            q_entry.value   = INIT_FINAL_BYTE;
         end
         CMD_INSTR: begin
            q_entry.value = byte_value;
         end
         CMD_CHAR: begin
            q_entry.is_data = 1'b1;
            q_entry.value   = mapped;
         end
         CMD_RAW: begin
            q_entry.is_data = 1'b1;
         end
         CMD_CURSOR: begin
            q_entry.value = base + column;
         end
         default: begin
            cmd_known = 1'b0;
         end
      endcase
   end

   // unknown commands are taken and dropped
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && cmd_known;

endmodule

// ----- rtl/core/lcd_seq_queue.sv -----
// Short register FIFO of classified commands between front and back end.
// Depends on lcd_seq_pkg.
`timescale 1ns / 1ps

module lcd_seq_queue
   import lcd_seq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output cmd_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_entry_type    slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/lcd_seq_back.sv -----
// Back end: per queued command, runs the init table (init only) and the byte-write
// segments, one per cycle to an output register unless stalled. Uses lcd_seq_pkg.
`timescale 1ns / 1ps

module lcd_seq_back
   import lcd_seq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output seg_type       rsp_seg
);

   cmd_entry_type cur_ff;
   logic          busy_ff, busy_in;
   logic [5:0]    step_ff, step_in;
   logic          rs_level_ff, rs_level_in;
   logic          rsp_valid_ff, rsp_valid_in;
   seg_type       rsp_seg_ff;

   seg_type       seg;
   logic [5:0]    byte_off;
   logic [2:0]    byte_idx;
   logic          out_free;
   logic          emit;
   logic          final_step;
   logic          load;

   assign byte_off   = step_ff - BYTE_START;
   assign byte_idx   = byte_off[2:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = busy_ff && out_free;
   assign final_step = (step_ff == STEP_FINAL);
   // take the next command in the same cycle the last segment leaves
   assign load       = q_valid && (!busy_ff || (emit && final_step));
   assign q_pop      = load;

   always_comb begin
      seg.last       = final_step;
      seg.reg_select = cur_ff.is_data;
      seg.enable     = 1'b0;
      seg.data_nibble = 4'h0;
      seg.hold_ms    = 5'd3;
      if (step_ff < BYTE_START) begin
         seg.reg_select  = rs_level_ff;
         seg.enable      = INIT_EN[step_ff];
         seg.data_nibble = INIT_NIB[step_ff];
         seg.hold_ms     = INIT_HOLD[step_ff];
      end else begin
         case (byte_idx)
            3'd0: begin
               seg.reg_select = rs_level_ff;
            end
            3'd1: begin
               seg.enable  = 1'b1;
               seg.hold_ms = 5'd1;
            end
            3'd2: begin
               seg.enable      = 1'b1;
               seg.data_nibble = cur_ff.value[7:4];
               seg.hold_ms     = 5'd2;
            end
            3'd3: begin
               seg.data_nibble = cur_ff.value[7:4];
               seg.hold_ms     = 5'd1;
            end
            3'd4: begin
               seg.enable  = 1'b1;
               seg.hold_ms = 5'd1;
            end
            3'd5: begin
               seg.enable      = 1'b1;
               seg.data_nibble = cur_ff.value[3:0];
               seg.hold_ms     = 5'd2;
            end
            3'd6: begin
               seg.data_nibble = cur_ff.value[3:0];
               seg.hold_ms     = 5'd1;
            end
            default: begin
               seg.hold_ms = 5'd3;
            end
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rs_level_in  = rs_level_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         step_in      = step_ff + 1'b1;
         if (final_step) begin
            busy_in     = 1'b0;
            rs_level_in = cur_ff.is_data;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         step_in = q_entry.is_init ? 6'd0 : BYTE_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rs_level_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rs_level_ff  <= rs_level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_entry;
      end
      if (emit) begin
         rsp_seg_ff <= seg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_seg    = rsp_seg_ff;

endmodule

// ----- rtl/core/char_lcd_nibble_write_sequencer.sv -----
// Character LCD 4-bit write sequencer: commands in, timed pin segments out.
// A command goes through the queue, then the back-end command and step
// registers, to the output register. Throughput: one segment per cycle
// unless rsp_tready stalls output; queued commands follow without a gap.
// Reset (synchronous, active high) empties the queue, drops the output and
// clears the RS level to instruction.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer
   import lcd_seq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value[7:0], row[10:8], column[18:11], zero pad
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // reg_select[0], enable[1], data_nibble[5:2],
                                    // hold_ms[10:6], zero pad
   output logic        rsp_tlast
);

   logic          q_full;
   logic          q_push;
   cmd_entry_type q_entry_in;
   logic          q_pop;
   logic          q_valid;
   cmd_entry_type q_head;
   seg_type       rsp_seg;

   lcd_seq_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser),
      .byte_value (req_tdata[7:0]),
      .row        (req_tdata[10:8]),
      .column     (req_tdata[18:11]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry_in)
   );

   lcd_seq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   lcd_seq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_seg    (rsp_seg)
   );

   assign rsp_tdata = {5'b0, rsp_seg.hold_ms, rsp_seg.data_nibble,
                       rsp_seg.enable, rsp_seg.reg_select};
   assign rsp_tlast = rsp_seg.last;

   // every command ends with E low, nibble cleared, 3 ms settle
   a_last_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tdata[1] == 1'b0 && rsp_tdata[5:2] == 4'h0 && rsp_tdata[10:6] == 5'd3))
      else $error("final segment is not a 3 ms idle");

   // segments of one command come without a gap
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a command's segment run");

   // no push is made into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
